// ===== hdl/gmb_pkg.sv =====
// Shared definitions for the grid maze backtracker: grid size, widths,
// event and direction codes, controller/datapath structs and helper functions.
// No dependencies.
package gmb_pkg;

    localparam int GRID_WIDTH  = 8;
    localparam int GRID_HEIGHT = 8;
    localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

    localparam int X_W     = $clog2(GRID_WIDTH);
    localparam int Y_W     = $clog2(GRID_HEIGHT);
    localparam int CIDX_W  = $clog2(CELL_COUNT);
    localparam int DEPTH_W = $clog2(CELL_COUNT + 1);

    // Port field widths are fixed by the interface.
    localparam int FIELD_W    = 3;
    localparam int CFG_W      = 3;
    localparam int CFG_ADDR_W = 1;
    localparam int RND_W      = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_START_X = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_Y = 1'd1;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    localparam logic [1:0] EV_START  = 2'd0;
    localparam logic [1:0] EV_CARVE  = 2'd1;
    localparam logic [1:0] EV_BACK   = 2'd2;
    localparam logic [1:0] EV_FINISH = 2'd3;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef logic [X_W-1:0]     t_xcoord;
    typedef logic [Y_W-1:0]     t_ycoord;
    typedef logic [CIDX_W-1:0]  t_cidx;
    typedef logic [DEPTH_W-1:0] t_depth;

    typedef struct packed {
        t_ycoord y;
        t_xcoord x;
    } t_cell;

    typedef struct packed {
        logic [1:0]         kind;
        logic [FIELD_W-1:0] from_x;
        logic [FIELD_W-1:0] from_y;
        logic [FIELD_W-1:0] to_x;
        logic [FIELD_W-1:0] to_y;
        logic [1:0]         dir;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic idle;
        logic capture;
        logic eval;
        logic commit;
    } t_cmd;

    // Status seen by the controller.
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_stat;

    function automatic t_cidx cell_index(input t_xcoord x, input t_ycoord y);
        return t_cidx'(y) * t_cidx'(GRID_WIDTH) + t_cidx'(x);
    endfunction

    // Residue mod 3 of a 16-bit value: four is one mod three, so 2-bit digits add up.
    function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] t;
        logic [2:0] u;
        s = '0;
        for (int k = 0; k < RND_W / 2; k++) begin
            s = s + 5'(v[2*k +: 2]);
        end
        t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        u = 3'(t[1:0]) + 3'(t[2]);
        return (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    // Random value reduced by a neighbor count of one to four.
    function automatic logic [1:0] mod_pick(input logic [RND_W-1:0] v, input logic [2:0] n);
        logic [1:0] r;
        case (n)
            3'd2:    r = {1'b0, v[0]};
            3'd3:    r = mod3_16(v);
            3'd4:    r = v[1:0];
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/gmb_ctrl.sv =====
// Controller state machine of the grid maze backtracker.
// Sequences capture, evaluate and commit of one request; uses gmb_pkg.
module gmb_ctrl
    import gmb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EVAL   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.idle    = 1'b1;
                o_cmd.capture = i_stat.in_valid;
                if (i_stat.in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = ST_COMMIT;
            end
            ST_COMMIT: begin
                // Hold the finished result until the output register is free.
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/gmb_datapath.sv =====
// Datapath of the grid maze backtracker: visited map, cell stack memory,
// stack depth and the neighbor selection logic; uses gmb_pkg.
module gmb_datapath
    import gmb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic             i_mode,
    input  logic [RND_W-1:0] i_rnd,
    input  logic [CFG_W-1:0] i_start_x,
    input  logic [CFG_W-1:0] i_start_y,
    output t_result          o_res
);

    logic [CELL_COUNT-1:0] r_visited;
    t_depth                r_depth;
    t_cell                 r_stack [CELL_COUNT];
    t_cell                 r_top;
    logic                  r_mode;
    logic [RND_W-1:0]      r_rnd;
    t_result               r_res;
    t_cell                 r_cell;
    t_cidx                 r_cell_idx;

    t_xcoord    w_sx;
    t_ycoord    w_sy;
    t_cidx      w_top_idx;
    logic [3:0] w_avail;
    logic [2:0] w_cnt;
    logic [1:0] w_pick;
    logic [2:0] w_seen;
    logic [1:0] w_sel;
    t_cell      w_next;
    t_cidx      w_next_idx;
    logic [1:0] w_dir;
    t_result    w_res;
    t_cell      w_cell;
    t_cidx      w_cell_idx;
    logic       w_we;
    t_cidx      w_waddr;

    // Entry cell, saturated to the last column or row.
    always_comb begin
        w_sx = (int'(i_start_x) < GRID_WIDTH)  ? t_xcoord'(i_start_x) : t_xcoord'(GRID_WIDTH - 1);
        w_sy = (int'(i_start_y) < GRID_HEIGHT) ? t_ycoord'(i_start_y) : t_ycoord'(GRID_HEIGHT - 1);
    end

    // Unvisited neighbors of the stack top, listed left, right, up, down.
    always_comb begin
        w_top_idx  = cell_index(r_top.x, r_top.y);
        w_avail[0] = (r_top.x != '0) && !r_visited[w_top_idx - t_cidx'(1)];
        w_avail[1] = (r_top.x != t_xcoord'(GRID_WIDTH - 1))
                     && !r_visited[w_top_idx + t_cidx'(1)];
        w_avail[2] = (r_top.y != '0) && !r_visited[w_top_idx - t_cidx'(GRID_WIDTH)];
        w_avail[3] = (r_top.y != t_ycoord'(GRID_HEIGHT - 1))
                     && !r_visited[w_top_idx + t_cidx'(GRID_WIDTH)];
        w_cnt  = 3'($countones(w_avail));
        w_pick = mod_pick(r_rnd, w_cnt);

        w_seen = '0;
        w_sel  = '0;
        for (int k = 0; k < 4; k++) begin
            if (w_avail[k] && (w_seen == {1'b0, w_pick})) begin
                w_sel = 2'(k);
            end
            w_seen = w_seen + 3'(w_avail[k]);
        end

        w_next     = r_top;
        w_next_idx = w_top_idx;
        w_dir      = DIR_LEFT;
        case (w_sel)
            2'd0: begin
                w_next.x   = r_top.x - t_xcoord'(1);
                w_next_idx = w_top_idx - t_cidx'(1);
                w_dir      = DIR_LEFT;
            end
            2'd1: begin
                w_next.x   = r_top.x + t_xcoord'(1);
                w_next_idx = w_top_idx + t_cidx'(1);
                w_dir      = DIR_RIGHT;
            end
            2'd2: begin
                w_next.y   = r_top.y - t_ycoord'(1);
                w_next_idx = w_top_idx - t_cidx'(GRID_WIDTH);
                w_dir      = DIR_UP;
            end
            default: begin
                w_next.y   = r_top.y + t_ycoord'(1);
                w_next_idx = w_top_idx + t_cidx'(GRID_WIDTH);
                w_dir      = DIR_DOWN;
            end
        endcase
    end

    // Result of the captured request and the cell it marks.
    always_comb begin
        w_res      = '0;
        w_cell     = w_next;
        w_cell_idx = w_next_idx;
        if (r_mode == MODE_START) begin
            w_res.kind   = EV_START;
            w_res.from_x = FIELD_W'(w_sx);
            w_res.from_y = FIELD_W'(w_sy);
            w_cell       = '{y: w_sy, x: w_sx};
            w_cell_idx   = cell_index(w_sx, w_sy);
        end else if (r_depth == '0) begin
            w_res.kind = EV_FINISH;
        end else if (w_cnt == '0) begin
            w_res.kind   = EV_BACK;
            w_res.from_x = FIELD_W'(r_top.x);
            w_res.from_y = FIELD_W'(r_top.y);
        end else begin
            w_res.kind   = EV_CARVE;
            w_res.from_x = FIELD_W'(r_top.x);
            w_res.from_y = FIELD_W'(r_top.y);
            w_res.to_x   = FIELD_W'(w_next.x);
            w_res.to_y   = FIELD_W'(w_next.y);
            w_res.dir    = w_dir;
        end
    end

    // Capture the request and evaluate it into the result and the cell to mark.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_rnd  <= i_rnd;
        end
        if (i_cmd.eval) begin
            r_res      <= w_res;
            r_cell     <= w_cell;
            r_cell_idx <= w_cell_idx;
        end
    end

    // Visited map and stack depth change only at commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_depth   <= '0;
        end else if (i_cmd.commit) begin
            case (r_res.kind)
                EV_START: begin
                    // A new walk leaves only the entry cell marked.
                    r_visited <= CELL_COUNT'(1) << r_cell_idx;
                    r_depth   <= t_depth'(1);
                end
                EV_CARVE: begin
                    r_visited[r_cell_idx] <= 1'b1;
                    if (r_depth < t_depth'(CELL_COUNT)) begin
                        r_depth <= r_depth + t_depth'(1);
                    end
                end
                EV_BACK: begin
                    r_depth <= r_depth - t_depth'(1);
                end
                default: begin
                    r_depth <= '0;
                end
            endcase
        end
    end

    assign w_we = i_cmd.commit && ((r_res.kind == EV_START)
                  || ((r_res.kind == EV_CARVE) && (r_depth < t_depth'(CELL_COUNT))));
    assign w_waddr = (r_res.kind == EV_START) ? '0 : t_cidx'(r_depth);

    // Cell stack: one write port, one registered read of the top entry.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_waddr] <= r_cell;
        end
        if (i_cmd.capture) begin
            r_top <= r_stack[t_cidx'(r_depth - t_depth'(1))];
        end
    end

    assign o_res = r_res;

endmodule

// ===== hdl/grid_maze_backtracker_top.sv =====
// Top level of the grid maze backtracker: stream ports, configuration
// registers and output register; uses gmb_pkg, gmb_ctrl and gmb_datapath.
//
// Usage: each request on the slave stream is one walk iteration. tuser[0]
// is the mode (0 starts a new maze at the configured entry cell, 1 takes one
// step), tdata carries the 16-bit random value used to pick a neighbor.
// Every request yields exactly one result on the master stream: tuser holds
// the event kind (started, wall carved, backtracked, finished), tdata the
// from cell, the to cell and the opened wall direction.
// The entry cell is set through the write port (index 0 column, 1 row); the user
// must write it only while the block is idle, which the block does not enforce.
// Each request passes through the stack memory read, the neighbor evaluation
// and the commit of the visited map and stack, and a new request is taken only
// after the previous one is committed.
// A new request is accepted while the previous result still waits; if the
// receiver stalls, the block holds the next result in its commit step until
// the output register is free.
// Reset clears the visited map, empties the stack and clears the entry cell
// to column 0, row 0; no clearing pass is needed.
module grid_maze_backtracker_top
    import gmb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Slave stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [15:0]           i_s_axis_tdata,   // [15:0] random_value
    input  logic [0:0]            i_s_axis_tuser,   // [0] mode
    // Master stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [2:0] from_x, [5:3] from_y, [8:6] to_x, [11:9] to_y, [13:12] direction
    output logic [15:0]           o_m_axis_tdata,
    output logic [1:0]            o_m_axis_tuser,   // [1:0] event_kind
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata
);

    logic [CFG_W-1:0] r_start_x;
    logic [CFG_W-1:0] r_start_y;
    t_result          r_out;
    logic             r_out_valid;

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_START_X: r_start_x <= i_cfg_wdata;
                REG_START_Y: r_start_y <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign w_stat.in_valid = i_s_axis_tvalid;
    assign w_stat.out_free = !r_out_valid || i_m_axis_tready;

    gmb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    gmb_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_mode    (i_s_axis_tuser[0]),
        .i_rnd     (i_s_axis_tdata),
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cmd.commit) begin
            r_out <= w_res;
        end
    end

    assign o_s_axis_tready = w_cmd.idle;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {2'b00, r_out.dir, r_out.to_y, r_out.to_x,
                              r_out.from_y, r_out.from_x};

endmodule
